[rtl/sitpd_pkg.sv]
package sitpd_pkg;

   localparam int VALUE_W       = 32;
   localparam int MIN_WIDTH_W   = 6;
   localparam int CHAR_W        = 8;
   localparam int BCD_DIGITS    = 10;
   localparam int BCD_W         = 4 * BCD_DIGITS;
   localparam int CONV_CNT_W    = $clog2(VALUE_W);
   localparam int ND_W          = $clog2(BCD_DIGITS + 1);
   localparam int MAX_WIDTH_DEF = 32;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [MIN_WIDTH_W-1:0]    min_width;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              is_last;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CONV,
      S_NORM,
      S_SIGN,
      S_PAD,
      S_DIGIT
   } state_type;

endpackage

[rtl/signed_int_to_padded_decimal_unit.sv]
// A taken number goes through the bit-serial binary-to-BCD shift loop, then the
// leading zero digits are stripped, then the text (1 to the larger of MAX_WIDTH and
// 11 characters) is sent one character per cycle. No new number is taken while
// busy is high; busy stays high until the last character of the serial emit.
// Reset (synchronous, active high) returns the controller to idle; results are
// strobed for one cycle and the receiver cannot stall them.
module signed_int_to_padded_decimal_unit #(
   parameter int MAX_WIDTH = sitpd_pkg::MAX_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  sitpd_pkg::req_type req_in,
   output logic               rsp_valid,
   output sitpd_pkg::rsp_type rsp_out
);

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int VW = sitpd_pkg::VALUE_W;
   localparam int BW = sitpd_pkg::BCD_W;
   localparam int NW = sitpd_pkg::ND_W;
   localparam int KW = sitpd_pkg::CONV_CNT_W;

   sitpd_pkg::state_type state_ff, state_in;

   logic [VW-1:0] mag_ff, mag_in;
   logic [BW-1:0] bcd_ff, bcd_in;
   logic [KW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] nd_ff, nd_in;
   logic          neg_ff, neg_in;
   logic [CW-1:0] wsat_ff, wsat_in;
   logic [CW-1:0] pad_ff, pad_in;

   logic          accept;
   logic [BW-1:0] bcd_adj;
   logic [3:0]    top_digit;
   logic          norm_done;
   logic [CW-1:0] len;
   logic [CW-1:0] pad_calc;

   assign accept    = start && (state_ff == sitpd_pkg::S_IDLE);
   assign top_digit = bcd_ff[BW-1 -: 4];
   assign norm_done = (top_digit != 4'd0) || (nd_ff == NW'(1));
   assign len       = CW'(nd_ff) + CW'(neg_ff);
   assign pad_calc  = (wsat_ff > len) ? (wsat_ff - len) : '0;

   always_comb begin
      for (int i = 0; i < sitpd_pkg::BCD_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sitpd_pkg::S_IDLE: begin
            if (start) state_in = sitpd_pkg::S_CONV;
         end
         sitpd_pkg::S_CONV: begin
            if (cnt_ff == '0) state_in = sitpd_pkg::S_NORM;
         end
         sitpd_pkg::S_NORM: begin
            if (norm_done) begin
               if (neg_ff) state_in = sitpd_pkg::S_SIGN;
               else if (pad_calc != '0) state_in = sitpd_pkg::S_PAD;
               else state_in = sitpd_pkg::S_DIGIT;
            end
         end
         sitpd_pkg::S_SIGN: begin
            if (pad_ff != '0) state_in = sitpd_pkg::S_PAD;
            else state_in = sitpd_pkg::S_DIGIT;
         end
         sitpd_pkg::S_PAD: begin
            if (pad_ff == CW'(1)) state_in = sitpd_pkg::S_DIGIT;
         end
         sitpd_pkg::S_DIGIT: begin
            if (nd_ff == NW'(1)) state_in = sitpd_pkg::S_IDLE;
         end
         default: state_in = sitpd_pkg::S_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      mag_in  = mag_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      nd_in   = nd_ff;
      neg_in  = neg_ff;
      wsat_in = wsat_ff;
      pad_in  = pad_ff;
      if (accept) begin
         neg_in = req_in.value[VW-1];
         mag_in = req_in.value[VW-1] ? (~req_in.value + VW'(1)) : req_in.value;
         bcd_in = '0;
         cnt_in = KW'(VW - 1);
         nd_in  = NW'(sitpd_pkg::BCD_DIGITS);
         if (req_in.value == '0) begin
            wsat_in = '0;
         end else if (32'(req_in.min_width) > 32'(MAX_WIDTH)) begin
            wsat_in = CW'(MAX_WIDTH);
         end else begin
            wsat_in = CW'(req_in.min_width);
         end
      end else begin
         case (state_ff)
            sitpd_pkg::S_CONV: begin
               bcd_in = {bcd_adj[BW-2:0], mag_ff[VW-1]};
               mag_in = {mag_ff[VW-2:0], 1'b0};
               cnt_in = cnt_ff - KW'(1);
            end
            sitpd_pkg::S_NORM: begin
               if (norm_done) begin
                  pad_in = pad_calc;
               end else begin
                  bcd_in = {bcd_ff[BW-5:0], 4'd0};
                  nd_in  = nd_ff - NW'(1);
               end
            end
            sitpd_pkg::S_PAD: begin
               pad_in = pad_ff - CW'(1);
            end
            sitpd_pkg::S_DIGIT: begin
               bcd_in = {bcd_ff[BW-5:0], 4'd0};
               nd_in  = nd_ff - NW'(1);
            end
            default: ;
         endcase
      end
   end

   // outputs
   always_comb begin
      busy             = (state_ff != sitpd_pkg::S_IDLE);
      rsp_valid        = 1'b0;
      rsp_out.out_char = sitpd_pkg::CHAR_ZERO;
      rsp_out.is_last  = 1'b0;
      unique case (state_ff)
         sitpd_pkg::S_SIGN: begin
            rsp_valid        = 1'b1;
            rsp_out.out_char = sitpd_pkg::CHAR_MINUS;
         end
         sitpd_pkg::S_PAD: begin
            rsp_valid = 1'b1;
         end
         sitpd_pkg::S_DIGIT: begin
            rsp_valid        = 1'b1;
            rsp_out.out_char = sitpd_pkg::CHAR_ZERO + {4'd0, top_digit};
            rsp_out.is_last  = (nd_ff == NW'(1));
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sitpd_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      bcd_ff  <= bcd_in;
      cnt_ff  <= cnt_in;
      nd_ff   <= nd_in;
      neg_ff  <= neg_in;
      wsat_ff <= wsat_in;
      pad_ff  <= pad_in;
   end

`ifndef SYNTH
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe outside a conversion");

   a_no_out_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid)
      else $error("result strobe right after accept");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out.is_last) |=> (!rsp_valid && !busy))
      else $error("transfer after last character");

   a_digit_bcd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sitpd_pkg::S_DIGIT) |-> (top_digit <= 4'd9))
      else $error("non-decimal digit emitted");
`endif

endmodule

[bench/signed_int_to_padded_decimal_unit_test.sv]
module signed_int_to_padded_decimal_unit_test;

   localparam int MAX_W       = sitpd_pkg::MAX_WIDTH_DEF;
   localparam int CHAR_W      = sitpd_pkg::CHAR_W;
   localparam int RANDOM_NUMS = 406;
   localparam int N_CORNERS   = 24;

   class decimal_text_checker;
      sitpd_pkg::rsp_type pending_chars[$];
      int      errors    = 0;
      int      numbers   = 0;
      int      negatives = 0;
      int      padded    = 0;
      int      zeros     = 0;
      int      chars     = 0;

      // Expected text of one accepted number, queued one character at a time.
      function void add_number(sitpd_pkg::req_type item);
         logic [31:0]      raw;
         logic [31:0]      mag;
         logic             neg;
         logic [3:0]       digs [10];
         logic [CHAR_W-1:0] text[$];
         int unsigned      nd;
         int unsigned      len;
         int unsigned      width;
         int unsigned      total;
         sitpd_pkg::rsp_type c;
         raw = item.value;
         neg = raw[31];
         mag = neg ? (~raw + 32'd1) : raw;
         numbers++;
         if (raw == 32'd0) begin
            zeros++;
            c.out_char = sitpd_pkg::CHAR_ZERO;
            c.is_last  = 1'b1;
            pending_chars.push_back(c);
            return;
         end
         nd = 0;
         while (mag != 32'd0) begin
            digs[nd] = 4'(mag % 32'd10);
            mag      = mag / 32'd10;
            nd++;
         end
         len   = nd + (neg ? 1 : 0);
         width = item.min_width;
         if (width > MAX_W)
            width = MAX_W;
         total = (width > len) ? width : len;
         if (neg) begin
            negatives++;
            text.push_back(sitpd_pkg::CHAR_MINUS);
         end
         if (total > len)
            padded++;
         repeat (total - len) text.push_back(sitpd_pkg::CHAR_ZERO);
         for (int k = nd; k > 0; k--)
            text.push_back(sitpd_pkg::CHAR_ZERO + CHAR_W'(digs[k-1]));
         foreach (text[i]) begin
            c.out_char = text[i];
            c.is_last  = (i == text.size() - 1);
            pending_chars.push_back(c);
         end
      endfunction

      function void check_char(sitpd_pkg::rsp_type got);
         sitpd_pkg::rsp_type want;
         chars++;
         if (pending_chars.size() == 0) begin
            $display("%0t: unexpected character: expected none, actual char=%h last=%b",
                     $time, got.out_char, got.is_last);
            errors++;
            return;
         end
         want = pending_chars.pop_front();
         if (got.out_char !== want.out_char) begin
            $display("%0t: out_char mismatch: expected %h, actual %h",
                     $time, want.out_char, got.out_char);
            errors++;
         end
         if (got.is_last !== want.is_last) begin
            $display("%0t: is_last mismatch: expected %b, actual %b",
                     $time, want.is_last, got.is_last);
            errors++;
         end
      endfunction
   endclass

   logic    clock  = 1'b0;
   logic    reset  = 1'b1;
   logic    start  = 1'b0;
   sitpd_pkg::req_type req_in = '0;
   logic    busy;
   logic    rsp_valid;
   sitpd_pkg::rsp_type rsp_out;

   decimal_text_checker sb;
   int burst_left = 0;

   logic [31:0] corner_value [N_CORNERS] = '{
      32'd0, 32'd0, 32'd0, 32'd1, -32'd1, -32'd1,
      32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
      32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
      32'd123, -32'd123, -32'd123, -32'd123,
      32'd9, 32'd10, 32'd999999999, 32'd1000000000,
      32'd42, -32'd42, 32'd7
   };
   logic [5:0] corner_width [N_CORNERS] = '{
      6'd0, 6'd32, 6'd63, 6'd0, 6'd0, 6'd32,
      6'd0, 6'd10, 6'd11,
      6'd0, 6'd11, 6'd12, 6'd63,
      6'd5, 6'd5, 6'd4, 6'd3,
      6'd1, 6'd2, 6'd9, 6'd63,
      6'd33, 6'd40, 6'd31
   };

   signed_int_to_padded_decimal_unit #(
      .MAX_WIDTH(MAX_W)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_in   (req_in),
      .rsp_valid(rsp_valid),
      .rsp_out  (rsp_out)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_char(rsp_out);
   end

   function automatic int idle_len();
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         burst_left = $urandom_range(10, 30);
         return 0;
      end
      if ($urandom_range(0, 11) == 0)
         return $urandom_range(20, 80);
      return $urandom_range(0, 3);
   endfunction

   function automatic sitpd_pkg::req_type random_number();
      sitpd_pkg::req_type item;
      int          v;
      int          p;
      logic [31:0] edges [6] = '{32'h8000_0000, 32'h7fff_ffff, 32'd0,
                                 32'hffff_ffff, 32'd1, 32'h8000_0001};
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $urandom;
         4, 5:       v = int'($urandom_range(0, 2000)) - 1000;
         6: begin
            p = 1;
            repeat ($urandom_range(0, 9)) p = p * 10;
            v = p - 1 + int'($urandom_range(0, 2));
            if ($urandom_range(0, 1))
               v = -v;
         end
         7:       v = edges[$urandom_range(0, 5)];
         default: v = int'($urandom_range(0, 999999)) * ($urandom_range(0, 1) ? -1 : 1);
      endcase
      item.value = v;
      case ($urandom_range(0, 3))
         0:       item.min_width = 6'd0;
         1:       item.min_width = 6'($urandom_range(1, 12));
         2:       item.min_width = 6'($urandom_range(10, 32));
         default: item.min_width = 6'($urandom_range(0, 63));
      endcase
      return item;
   endfunction

   // One transfer: hold start until the unit takes it, then idle for gap cycles.
   task automatic send_number(input sitpd_pkg::req_type item, input int gap);
      req_in <= item;
      start  <= 1'b1;
      do @(posedge clock); while (busy);
      sb.add_number(item);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      sitpd_pkg::req_type item;
      sb = new;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < N_CORNERS; i++) begin
         item.value     = corner_value[i];
         item.min_width = corner_width[i];
         send_number(item, idle_len());
      end
      for (int i = 0; i < RANDOM_NUMS; i++)
         send_number(random_number(), idle_len());
      start <= 1'b0;
      while (sb.pending_chars.size() > 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("Converted %0d numbers: %0d negative, %0d zero-padded, %0d zero.",
               sb.numbers, sb.negatives, sb.padded, sb.zeros);
      $display("Checked %0d characters, %0d mismatches.", sb.chars, sb.errors);
      if (sb.errors == 0) begin
         $display("** signed_int_to_padded_decimal_unit: PASSED **");
      end else begin
         $display("** signed_int_to_padded_decimal_unit: FAILED **");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d characters outstanding.", sb.pending_chars.size());
      $display("** signed_int_to_padded_decimal_unit: FAILED **");
      $finish;
   end

endmodule
